>>> rtl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

   // Fixed widths of the request and result fields.
   localparam int REQ_TYPE_WIDTH  = 3;
   localparam int VALUE_WIDTH     = 32;
   localparam int STATUS_WIDTH    = 2;
   localparam int COUNT_OUT_WIDTH = 7;

   // Request codes. Codes above query act as a query.
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_PUSH_LEFT  = 3'd0;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_PUSH_RIGHT = 3'd1;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_POP_LEFT   = 3'd2;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_POP_RIGHT  = 3'd3;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_QUERY      = 3'd4;

   // Status codes of a result.
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_POP_EMPTY  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_PUSH_FULL  = 2'd2;

   // Operation broadcast to every cell; at most one bit is set, and only when
   // the operation is allowed by the current fill state.
   typedef struct packed {
      logic push_left;
      logic push_right;
      logic pop_left;
      logic pop_right;
   } cmd_type;

endpackage

>>> rtl/dq_req_if.sv
`timescale 1ns / 1ps

interface dq_req_if import dq_pkg::*; ();
   logic                            valid;
   logic                            ready;
   logic        [REQ_TYPE_WIDTH-1:0] req_type;
   logic signed [VALUE_WIDTH-1:0]    value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

>>> rtl/dq_rsp_if.sv
`timescale 1ns / 1ps

interface dq_rsp_if import dq_pkg::*; ();
   logic                             valid;
   logic                             ready;
   logic        [STATUS_WIDTH-1:0]    status;
   logic signed [VALUE_WIDTH-1:0]     left_value;
   logic signed [VALUE_WIDTH-1:0]     right_value;
   logic        [COUNT_OUT_WIDTH-1:0] count;
   logic                             is_empty;

   modport source (output valid, output status, output left_value, output right_value,
                   output count, output is_empty, input ready);
   modport sink   (input valid, input status, input left_value, input right_value,
                   input count, input is_empty, output ready);
endinterface

>>> rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// A request item updates the cell row and the status register when it is accepted;
// its result is then loaded into the result register once any earlier result is taken.
// A new item is not accepted until the result of the last one has been loaded.
// An item passes through the cell row update and then the end value select.
// Reset clears the occupancy of every cell, the count and the result valid flag;
// stored data is not cleared and is never read before it is written.

module double_ended_queue import dq_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   dq_req_if.sink   req_if,
   dq_rsp_if.source rsp_if
);

   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // The queue lives in a row of cells. Cell 0 is the left end and the
   // occupied cells form an unbroken run from there. A push or pop at the
   // left end shifts the whole row by one place; a push at the right end
   // fills the first free cell and a pop there frees the last occupied one.

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DATA_WIDTH-1:0] cell_tail [DEPTH];
   logic [DEPTH-1:0]      cell_valid;

   logic [DATA_WIDTH-1:0] push_data;
   logic                  is_full;
   logic                  is_void;
   logic                  accept;
   cmd_type               cmd;
   logic [STATUS_WIDTH-1:0] status_now;

   logic                   busy_ff;
   logic [STATUS_WIDTH-1:0] status_ff;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;

   logic                          rsp_valid_ff;
   logic [STATUS_WIDTH-1:0]        rsp_status_ff;
   logic [VALUE_WIDTH-1:0]         rsp_left_ff, rsp_left_in;
   logic [VALUE_WIDTH-1:0]         rsp_right_ff, rsp_right_in;
   logic [COUNT_OUT_WIDTH-1:0]     rsp_count_ff, rsp_count_in;
   logic                          rsp_empty_ff;
   logic                          rsp_load;

   logic [DATA_WIDTH-1:0] left_raw;
   logic [DATA_WIDTH-1:0] right_raw;

   // A pushed value is sign-extended from 32 bits, or truncated, to DATA_WIDTH bits.
   generate
      if (DATA_WIDTH <= VALUE_WIDTH) begin : g_in_narrow
         assign push_data = req_if.value[DATA_WIDTH-1:0];
      end else begin : g_in_wide
         assign push_data = {{(DATA_WIDTH-VALUE_WIDTH){req_if.value[VALUE_WIDTH-1]}},
                             req_if.value};
      end
   endgenerate

   assign is_full = cell_valid[DEPTH-1];
   assign is_void = !cell_valid[0];

   // One item is in flight at a time: it updates the row in the cycle it is
   // accepted and its result is formed from the settled row afterwards.
   assign req_if.ready = !busy_ff;
   assign accept       = req_if.valid && !busy_ff;

   always_comb begin
      cmd        = '0;
      status_now = STATUS_OK;
      if (accept) begin
         unique case (req_if.req_type)
            REQ_PUSH_LEFT: begin
               if (is_full) begin
                  status_now = STATUS_PUSH_FULL;
               end else begin
                  cmd.push_left = 1'b1;
               end
            end
            REQ_PUSH_RIGHT: begin
               if (is_full) begin
                  status_now = STATUS_PUSH_FULL;
               end else begin
                  cmd.push_right = 1'b1;
               end
            end
            REQ_POP_LEFT: begin
               if (is_void) begin
                  status_now = STATUS_POP_EMPTY;
               end else begin
                  cmd.pop_left = 1'b1;
               end
            end
            REQ_POP_RIGHT: begin
               if (is_void) begin
                  status_now = STATUS_POP_EMPTY;
               end else begin
                  cmd.pop_right = 1'b1;
               end
            end
            default: begin
               // A query, and any unused code, leaves the queue untouched.
            end
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push_left || cmd.push_right) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (cmd.pop_left || cmd.pop_right) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   // The row of cells. The left end of the row is fed with the pushed value
   // as an always occupied neighbour; the right end sees an empty one.
   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic [DATA_WIDTH-1:0] left_d;
         logic                  left_v;
         logic [DATA_WIDTH-1:0] right_d;
         logic                  right_v;

         if (i == 0) begin : g_first
            assign left_d = push_data;
            assign left_v = 1'b1;
         end else begin : g_inner_left
            assign left_d = cell_data[i-1];
            assign left_v = cell_valid[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign right_d = '0;
            assign right_v = 1'b0;
         end else begin : g_inner_right
            assign right_d = cell_data[i+1];
            assign right_v = cell_valid[i+1];
         end

         dq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .push_data   (push_data),
            .left_data   (left_d),
            .left_valid  (left_v),
            .right_data  (right_d),
            .right_valid (right_v),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .tail_part   (cell_tail[i])
         );
      end
   endgenerate

   // The right end is the one occupied cell whose right neighbour is empty, so its
   // value is picked by a one-hot select over the row. An empty queue selects
   // nothing and reads as zero.
   always_comb begin
      right_raw = '0;
      for (int i = 0; i < DEPTH; i++) begin
         right_raw = right_raw | cell_tail[i];
      end
   end

   assign left_raw = cell_data[0] & {DATA_WIDTH{cell_valid[0]}};

   // Stored values are sign-extended, or truncated, from DATA_WIDTH bits to the 32-bit result.
   generate
      if (DATA_WIDTH >= VALUE_WIDTH) begin : g_out_wide
         assign rsp_left_in  = left_raw[VALUE_WIDTH-1:0];
         assign rsp_right_in = right_raw[VALUE_WIDTH-1:0];
      end else begin : g_out_narrow
         assign rsp_left_in  = {{(VALUE_WIDTH-DATA_WIDTH){left_raw[DATA_WIDTH-1]}}, left_raw};
         assign rsp_right_in = {{(VALUE_WIDTH-DATA_WIDTH){right_raw[DATA_WIDTH-1]}},
                                right_raw};
      end

      if (COUNT_WIDTH >= COUNT_OUT_WIDTH) begin : g_cnt_wide
         assign rsp_count_in = count_ff[COUNT_OUT_WIDTH-1:0];
      end else begin : g_cnt_narrow
         assign rsp_count_in = {{(COUNT_OUT_WIDTH-COUNT_WIDTH){1'b0}}, count_ff};
      end
   endgenerate

   // The result register is loaded once the row has settled and any earlier
   // result has been taken.
   assign rsp_load = busy_ff && (!rsp_valid_ff || rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (rsp_load) begin
            busy_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_now;
      end
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_left_ff   <= rsp_left_in;
         rsp_right_ff  <= rsp_right_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_empty_ff  <= !cell_valid[0];
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.left_value  = rsp_left_ff;
   assign rsp_if.right_value = rsp_right_ff;
   assign rsp_if.count       = rsp_count_ff;
   assign rsp_if.is_empty    = rsp_empty_ff;

endmodule

>>> rtl/dq_cell.sv
`timescale 1ns / 1ps

module dq_cell import dq_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [DATA_WIDTH-1:0] push_data,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic                  left_valid,
   input  logic [DATA_WIDTH-1:0] right_data,
   input  logic                  right_valid,
   output logic [DATA_WIDTH-1:0] data,
   output logic                  valid,
   output logic [DATA_WIDTH-1:0] tail_part
);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  valid_ff, valid_in;

   // Occupied cells always form a run starting at the left end of the row.
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      priority if (cmd.push_left) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (cmd.pop_left) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (cmd.push_right) begin
         if (!valid_ff && left_valid) begin
            data_in  = push_data;
            valid_in = 1'b1;
         end
      end else if (cmd.pop_right) begin
         if (valid_ff && !right_valid) begin
            valid_in = 1'b0;
         end
      end else begin
         // No operation this cycle: the cell holds its contents.
         data_in  = data_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign valid     = valid_ff;
   // Only the last occupied cell contributes to the right end value.
   assign tail_part = data_ff & {DATA_WIDTH{valid_ff & !right_valid}};

endmodule
